/* hdl/bbfc16_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// bbfc16_pkg: shared definitions for the binary block framer
// Sync bytes, status codes, size limits and the byte-wide CRC16-CCITT update.
// ---------------------------------------------------------------------------
package bbfc16_pkg;

	// Largest accepted block in bytes, also the widest position count.
	localparam int unsigned MAX_FRAME_BYTES = 4096;
	localparam int unsigned POS_W           = 13;
	localparam int unsigned MIN_FRAME_BYTES = 8;

	localparam logic [7:0]  SYNC_FIRST  = 8'h24;
	localparam logic [7:0]  SYNC_SECOND = 8'h40;
	localparam logic [15:0] CRC_POLY    = 16'h1021;

	localparam logic [2:0] ST_BUSY     = 3'd0;
	localparam logic [2:0] ST_DONE     = 3'd1;
	localparam logic [2:0] ST_BAD_SYNC = 3'd2;
	localparam logic [2:0] ST_BAD_LEN  = 3'd3;
	localparam logic [2:0] ST_BAD_CRC  = 3'd4;

	// One byte of CRC16-CCITT, MSB first, not reflected.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
	                                           input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage : bbfc16_pkg
`default_nettype wire

/* hdl/binary_block_framer_crc16.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// binary_block_framer_crc16: byte-stream framer for CRC-checked binary blocks
// Frames '$' '@' crc16 id16 len16 payload blocks and reports one status per
// received byte.
// ---------------------------------------------------------------------------
//
//  Channel | Handshake          | Payload
//  --------+--------------------+-------------------------------------------
//  rx      | rx_valid/rx_stall  | rx_byte
//  res     | res_valid/res_stall| status, frame_id, frame_rev, frame_length
//
// One byte is taken in every cycle unless rx_stall is raised; each byte
// yields exactly one result transaction, through the input register
// and the result register. The framing state and the CRC update live
// between those two registers, so one byte-wide CRC step sets the cycle.
// The asynchronous reset arst_n clears the framer to idle with a zero CRC.
// A stall on the result side holds the result register; the input register
// keeps taking bytes until it too holds an unprocessed byte, and only then
// rx_stall is raised.
//
module binary_block_framer_crc16 (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        rx_valid,
	output logic             rx_stall,
	input  wire logic [7:0]  rx_byte,
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic [2:0]       status,
	output logic [12:0]      frame_id,
	output logic [2:0]       frame_rev,
	output logic [12:0]      frame_length
);
	import bbfc16_pkg::*;

	// Input register.
	logic              valid_s1;
	logic [7:0]        byte_s1;

	// Framing state.
	logic [POS_W-1:0]  byte_position_q;
	logic [15:0]       crc_running_q;
	logic [15:0]       crc_received_q;
	logic [7:0]        id_low_byte_q;
	logic [12:0]       held_frame_id_q;
	logic [2:0]        held_frame_rev_q;
	logic [POS_W-1:0]  expected_length_q;

	// Next-state and result values.
	logic [POS_W-1:0]  pos;
	logic [15:0]       crc_upd;
	logic [15:0]       len16;
	logic              len_bad;
	logic [POS_W-1:0]  chk_len;
	logic              check_end;
	logic              restart;
	logic [POS_W-1:0]  nxt_pos;
	logic [15:0]       nxt_crc;
	logic [15:0]       nxt_crc_rx;
	logic [7:0]        nxt_id_low;
	logic [12:0]       nxt_id;
	logic [2:0]        nxt_rev;
	logic [POS_W-1:0]  nxt_exp;
	logic [2:0]        r_status;
	logic [12:0]       r_id;
	logic [2:0]        r_rev;
	logic [12:0]       r_len;

	logic              advance;

	// The byte in the input register is processed when the result register
	// is empty or is being emptied in this cycle.
	assign advance  = valid_s1 && (!res_valid || !res_stall);
	assign rx_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	// Framing decision for the byte in the input register.
	always_comb begin
		pos        = byte_position_q + POS_W'(1);
		crc_upd    = crc16_byte(crc_running_q, byte_s1);
		len16      = {byte_s1, expected_length_q[7:0]};
		len_bad    = (len16 < 16'(MIN_FRAME_BYTES)) ||
		             (len16 > 16'(MAX_FRAME_BYTES)) ||
		             (len16[1:0] != 2'b00);
		chk_len    = expected_length_q;
		check_end  = 1'b0;
		restart    = 1'b0;
		nxt_pos    = pos;
		// The CRC covers bytes five onward; the sync and CRC bytes keep it at zero.
		nxt_crc    = (pos <= POS_W'(4)) ? 16'h0000 : crc_upd;
		nxt_crc_rx = crc_received_q;
		nxt_id_low = id_low_byte_q;
		nxt_id     = held_frame_id_q;
		nxt_rev    = held_frame_rev_q;
		nxt_exp    = expected_length_q;
		r_status   = ST_BUSY;
		r_id       = '0;
		r_rev      = '0;
		r_len      = '0;

		case (pos)
			POS_W'(1): begin
				// Hunting for a start byte is not a failure.
				if (byte_s1 != SYNC_FIRST) begin
					nxt_pos = '0;
				end
			end
			POS_W'(2): begin
				if (byte_s1 != SYNC_SECOND) begin
					r_status = ST_BAD_SYNC;
					restart  = 1'b1;
				end
			end
			POS_W'(3): nxt_crc_rx = {8'h00, byte_s1};
			POS_W'(4): nxt_crc_rx = {byte_s1, crc_received_q[7:0]};
			POS_W'(5): nxt_id_low = byte_s1;
			POS_W'(6): begin
				nxt_id  = {byte_s1[4:0], id_low_byte_q};
				nxt_rev = byte_s1[7:5];
			end
			POS_W'(7): nxt_exp = POS_W'(byte_s1);
			POS_W'(8): begin
				if (len_bad) begin
					r_status = ST_BAD_LEN;
					nxt_exp  = '0;
					restart  = 1'b1;
				end else begin
					nxt_exp   = len16[POS_W-1:0];
					chk_len   = len16[POS_W-1:0];
					check_end = 1'b1;
				end
			end
			default: check_end = 1'b1;
		endcase

		if (check_end && pos == chk_len) begin
			if (crc_upd == crc_received_q) begin
				r_status = ST_DONE;
				r_id     = held_frame_id_q;
				r_rev    = held_frame_rev_q;
				r_len    = chk_len;
				nxt_pos  = '0;
				nxt_crc  = '0;
			end else begin
				r_status = ST_BAD_CRC;
				restart  = 1'b1;
			end
		end else if (check_end && pos > chk_len) begin
			// Running past the block end cannot happen; treated as bad length.
			r_status = ST_BAD_LEN;
			restart  = 1'b1;
		end

		// After any failure the failing byte is itself tried as a new start.
		if (restart) begin
			nxt_crc = '0;
			nxt_pos = (byte_s1 == SYNC_FIRST) ? POS_W'(1) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q   <= '0;
			crc_running_q     <= '0;
			crc_received_q    <= '0;
			id_low_byte_q     <= '0;
			held_frame_id_q   <= '0;
			held_frame_rev_q  <= '0;
			expected_length_q <= '0;
			res_valid         <= 1'b0;
		end else begin
			if (advance) begin
				byte_position_q   <= nxt_pos;
				crc_running_q     <= nxt_crc;
				crc_received_q    <= nxt_crc_rx;
				id_low_byte_q     <= nxt_id_low;
				held_frame_id_q   <= nxt_id;
				held_frame_rev_q  <= nxt_rev;
				expected_length_q <= nxt_exp;
				res_valid         <= 1'b1;
			end else if (!res_stall) begin
				res_valid <= 1'b0;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (advance) begin
			status       <= r_status;
			frame_id     <= r_id;
			frame_rev    <= r_rev;
			frame_length <= r_len;
		end
	end

	// A completed block always has a legal length.
	a_done_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_DONE |->
			frame_length >= 13'(MIN_FRAME_BYTES) && frame_length[1:0] == 2'b00)
		else $error("completed block with illegal length");

	// Block fields are only reported with a completed block.
	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status != ST_DONE |->
			frame_id == '0 && frame_rev == '0 && frame_length == '0)
		else $error("block fields set without a completed block");

	// Once the length is known the position stays inside the block.
	a_pos_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		byte_position_q >= POS_W'(8) |-> byte_position_q < expected_length_q)
		else $error("byte position ran past the block length");

	// A byte waiting in the input register is neither lost nor changed.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("pending input byte was dropped");

endmodule : binary_block_framer_crc16
`default_nettype wire

/* tb/sv/tb_binary_block_framer_crc16.sv */
// ---------------------------------------------------------------------------
// tb_binary_block_framer_crc16: self-checking bench for the block framer
// Feeds a byte stream of well-formed, damaged and noisy binary blocks into
// the framer, predicts the status of every byte with an independent framing
// model, and compares each result transaction field by field.
// ---------------------------------------------------------------------------
module tb_binary_block_framer_crc16;

	import bbfc16_pkg::*;

	// One result transaction of the framer.
	typedef struct packed {
		logic [2:0]  status;
		logic [12:0] id;
		logic [2:0]  rev;
		logic [12:0] flen;
	} frame_result_t;

	// One byte for the rx channel. Rows marked typed carry a hand-written
	// result that replaces the prediction; all others use the predictor.
	typedef struct packed {
		logic [7:0]    data;
		logic          typed;
		frame_result_t want;
	} rx_item_t;

	localparam frame_result_t IDLE_RES     = '{ST_BUSY, 13'd0, 3'd0, 13'd0};
	localparam frame_result_t BAD_SYNC_RES = '{ST_BAD_SYNC, 13'd0, 3'd0, 13'd0};
	localparam frame_result_t BAD_LEN_RES  = '{ST_BAD_LEN, 13'd0, 3'd0, 13'd0};
	localparam frame_result_t BAD_CRC_RES  = '{ST_BAD_CRC, 13'd0, 3'd0, 13'd0};

	// Cycles without any accepted transaction before the run is declared hung.
	// The longest legal quiet stretch is the forced receiver hold below.
	localparam int QUIET_LIMIT   = 5000;
	localparam int HOLD_CYCLES   = 400;
	localparam int PHASE_BYTES   = 110;
	localparam int DRAIN_CYCLES  = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        rx_valid = 1'b0;
	logic        rx_stall;
	logic [7:0]  rx_byte;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [2:0]  status;
	logic [12:0] frame_id;
	logic [2:0]  frame_rev;
	logic [12:0] frame_length;

	binary_block_framer_crc16 uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_valid     (rx_valid),
		.rx_stall     (rx_stall),
		.rx_byte      (rx_byte),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.status       (status),
		.frame_id     (frame_id),
		.frame_rev    (frame_rev),
		.frame_length (frame_length)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// -----------------------------------------------------------------------
	// Shared bench state
	// -----------------------------------------------------------------------
	rx_item_t      stream_q[$];        // bytes waiting to be offered
	rx_item_t      offered = '0;       // byte currently on the rx channel
	rx_item_t      next_item;
	frame_result_t status_q[$];        // predicted results not yet seen
	logic [7:0]    frame_buf[$];       // scratch block built by build_frame
	int unsigned   send_idle_pct = 0;
	int unsigned   recv_stall_pct = 0;
	logic          pressure_req = 1'b0;
	logic          pressure_served = 1'b0;
	int            hold_left = 0;
	int            quiet_cycles = 0;
	int            mismatches = 0;

	assign rx_byte = offered.data;

	// Framer state as the predictor sees it.
	logic [12:0] frm_pos = '0;
	logic [15:0] frm_crc = '0;
	logic [15:0] frm_crc_rx = '0;
	logic [7:0]  frm_id_lo = '0;
	logic [12:0] frm_id = '0;
	logic [2:0]  frm_rev = '0;
	logic [12:0] frm_len = '0;

	// -----------------------------------------------------------------------
	// Predictor
	// -----------------------------------------------------------------------

	// CRC16-CCITT, one byte, fed bit by bit from the MSB.
	function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc,
	                                               input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ b[i];
			c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
		end
		return c;
	endfunction

	// After a failure the framer starts over, and the failing byte itself
	// may open a new block if it is the first sync character.
	function automatic void restart_hunt(input logic [7:0] b);
		frm_crc = '0;
		frm_pos = (b == SYNC_FIRST) ? 13'd1 : 13'd0;
	endfunction

	// Advances the framing state by one byte and returns the status that
	// byte should produce. Positions count from one within a block.
	function automatic frame_result_t advance_framer(input logic [7:0] b);
		frame_result_t r;
		logic [12:0]   next_pos;
		logic [15:0]   word;
		logic          at_tail;
		r = IDLE_RES;
		at_tail = 1'b0;
		next_pos = frm_pos + 13'd1;
		// The CRC covers everything after the received CRC field.
		if (next_pos <= 13'd4) begin
			frm_crc = '0;
		end else begin
			frm_crc = crc_ccitt_step(frm_crc, b);
		end
		frm_pos = next_pos;
		case (next_pos)
			13'd1: begin
				if (b != SYNC_FIRST) begin
					frm_pos = '0;
				end
			end
			13'd2: begin
				if (b != SYNC_SECOND) begin
					r.status = ST_BAD_SYNC;
					restart_hunt(b);
				end
			end
			13'd3: frm_crc_rx = {8'h00, b};
			13'd4: frm_crc_rx = {b, frm_crc_rx[7:0]};
			13'd5: frm_id_lo = b;
			13'd6: begin
				word = {b, frm_id_lo};
				frm_id = word[12:0];
				frm_rev = word[15:13];
			end
			13'd7: frm_len = {5'd0, b};
			13'd8: begin
				word = {b, frm_len[7:0]};
				if (word < 16'(MIN_FRAME_BYTES) || word > 16'(MAX_FRAME_BYTES) ||
				    word[1:0] != 2'b00) begin
					r.status = ST_BAD_LEN;
					frm_len = '0;
					restart_hunt(b);
				end else begin
					frm_len = word[12:0];
					at_tail = 1'b1;
				end
			end
			default: at_tail = 1'b1;
		endcase
		if (at_tail && next_pos == frm_len) begin
			if (frm_crc == frm_crc_rx) begin
				r = '{ST_DONE, frm_id, frm_rev, frm_len};
				frm_pos = '0;
				frm_crc = '0;
			end else begin
				r.status = ST_BAD_CRC;
				restart_hunt(b);
			end
		end else if (at_tail && next_pos > frm_len) begin
			r.status = ST_BAD_LEN;
			restart_hunt(b);
		end
		return r;
	endfunction

	task automatic check_field(input string what, input logic [15:0] exp_v,
	                           input logic [15:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
			mismatches++;
		end
	endtask

	// Builds a complete block with a correct CRC into frame_buf: n bytes in
	// total, header fields as given, random payload.
	task automatic build_frame(input logic [15:0] id_word, input logic [15:0] len_word,
	                           input int n);
		logic [15:0] crc;
		frame_buf.delete();
		frame_buf.push_back(SYNC_FIRST);
		frame_buf.push_back(SYNC_SECOND);
		frame_buf.push_back(8'h00);
		frame_buf.push_back(8'h00);
		frame_buf.push_back(id_word[7:0]);
		frame_buf.push_back(id_word[15:8]);
		frame_buf.push_back(len_word[7:0]);
		frame_buf.push_back(len_word[15:8]);
		for (int i = 8; i < n; i++) begin
			frame_buf.push_back(8'($urandom_range(255)));
		end
		crc = '0;
		for (int i = 4; i < n; i++) begin
			crc = crc_ccitt_step(crc, frame_buf[i]);
		end
		frame_buf[2] = crc[7:0];
		frame_buf[3] = crc[15:8];
	endtask

	// -----------------------------------------------------------------------
	// Directed stimulus. Typed rows hold results that follow directly from
	// the framing rules; the rest are left to the predictor.
	// -----------------------------------------------------------------------
	rx_item_t directed_rows [0:25] = '{
		// Hunting: a stray byte while idle is not a sync failure.
		'{8'h00, 1'b1, IDLE_RES},
		'{SYNC_FIRST, 1'b1, IDLE_RES},
		// A '$' in place of '@' fails the sync and opens a new block at once.
		'{SYNC_FIRST, 1'b1, BAD_SYNC_RES},
		'{SYNC_SECOND, 1'b1, IDLE_RES},
		// Minimal 8-byte block with all-ones ID word: ID 0x1FFF, revision 7.
		'{8'h69, 1'b0, IDLE_RES},
		'{8'h0D, 1'b0, IDLE_RES},
		'{8'hFF, 1'b0, IDLE_RES},
		'{8'hFF, 1'b0, IDLE_RES},
		'{8'h08, 1'b0, IDLE_RES},
		'{8'h00, 1'b0, IDLE_RES},
		// Length 0xFFFF is far above the largest block.
		'{SYNC_FIRST, 1'b1, IDLE_RES},
		'{SYNC_SECOND, 1'b1, IDLE_RES},
		'{8'h00, 1'b0, IDLE_RES},
		'{8'h00, 1'b0, IDLE_RES},
		'{8'h00, 1'b0, IDLE_RES},
		'{8'h00, 1'b0, IDLE_RES},
		'{8'hFF, 1'b0, IDLE_RES},
		'{8'hFF, 1'b1, BAD_LEN_RES},
		// Minimal block carrying a zero CRC, which its contents do not match.
		'{SYNC_FIRST, 1'b1, IDLE_RES},
		'{SYNC_SECOND, 1'b1, IDLE_RES},
		'{8'h00, 1'b0, IDLE_RES},
		'{8'h00, 1'b0, IDLE_RES},
		'{8'h00, 1'b0, IDLE_RES},
		'{8'h00, 1'b0, IDLE_RES},
		'{8'h08, 1'b0, IDLE_RES},
		'{8'h00, 1'b1, BAD_CRC_RES}
	};

	// -----------------------------------------------------------------------
	// rx driver: offers the next queued byte unless it rolls an idle cycle.
	// A stalled transaction keeps its byte and valid until it is taken.
	// -----------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid <= 1'b0;
		end else if (!rx_valid || !rx_stall) begin
			if (stream_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				next_item = stream_q.pop_front();
				offered <= next_item;
				rx_valid <= 1'b1;
			end else begin
				rx_valid <= 1'b0;
			end
		end
	end

	// -----------------------------------------------------------------------
	// Result side back-pressure. A single long hold, counted here, lets the
	// framer fill up and push the stall back onto the rx channel.
	// -----------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else if (pressure_req && !pressure_served) begin
			pressure_served <= 1'b1;
			hold_left <= HOLD_CYCLES;
			res_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// -----------------------------------------------------------------------
	// Monitor: predicts on every accepted rx transaction, checks every
	// accepted result transaction against the oldest prediction, and
	// watches for a hung pipeline.
	// -----------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		frame_result_t want;
		logic          moved;
		if (arst_n) begin
			moved = 1'b0;
			if (rx_valid && !rx_stall) begin
				want = advance_framer(rx_byte);
				if (offered.typed) begin
					want = offered.want;
				end
				status_q.push_back(want);
				moved = 1'b1;
			end
			if (res_valid && !res_stall) begin
				moved = 1'b1;
				if (status_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, got status %0d",
					         $time, status);
					mismatches++;
				end else begin
					want = status_q.pop_front();
					check_field("status", 16'(want.status), 16'(status));
					check_field("frame_id", 16'(want.id), 16'(frame_id));
					check_field("frame_rev", 16'(want.rev), 16'(frame_rev));
					check_field("frame_length", 16'(want.flen), 16'(frame_length));
				end
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
				$display("binary_block_framer_crc16 test failed");
				$finish;
			end
		end
	end

	// -----------------------------------------------------------------------
	// Main sequence: reset, directed rows, then four random phases with
	// different idle and stall mixes.
	// -----------------------------------------------------------------------
	initial begin : main_seq
		rx_item_t    item;
		int          phase_bytes;
		int          n;
		int          idx;
		logic [15:0] len_word;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			stream_q.push_back(directed_rows[i]);
		end

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
				default: begin send_idle_pct = 27; recv_stall_pct = 27; end
			endcase
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				while (stream_q.size() > 32) begin
					@(negedge clk);
				end
				if (ph == 0 && phase_bytes >= 60) begin
					pressure_req = 1'b1;
				end
				n = ($urandom_range(9) == 0) ? 8 + 4 * $urandom_range(60)
				                             : 8 + 4 * $urandom_range(6);
				build_frame(16'($urandom), 16'(n), n);
				idx = $urandom_range(99);
				if (idx < 60) begin
					// Well-formed block, kept as built.
				end else if (idx < 72) begin
					// One flipped bit anywhere after the sync pair.
					idx = $urandom_range(n - 1, 2);
					frame_buf[idx] = frame_buf[idx] ^ (8'h01 << $urandom_range(7));
				end else if (idx < 82) begin
					// Header with an illegal length; the block ends at byte eight.
					case ($urandom_range(3))
						0: len_word = 16'($urandom_range(7));
						1: len_word = 16'(8 + 4 * $urandom_range(1021) + $urandom_range(3, 1));
						2: len_word = 16'($urandom_range(65535, MAX_FRAME_BYTES + 1));
						default: len_word = 16'(MAX_FRAME_BYTES + 4);
					endcase
					build_frame(16'($urandom), len_word, 8);
				end else if (idx < 92) begin
					// Broken block: cut short, or a wrong second sync byte.
					case ($urandom_range(2))
						0: frame_buf = frame_buf[0:$urandom_range(n - 2)];
						1: frame_buf[1] = SYNC_FIRST;
						default: begin
							frame_buf[1] = 8'($urandom_range(255));
							if (frame_buf[1] == SYNC_SECOND) begin
								frame_buf[1] = 8'h00;
							end
						end
					endcase
				end else begin
					// Line noise, rich in stray first sync characters.
					frame_buf.delete();
					repeat ($urandom_range(4, 1)) begin
						frame_buf.push_back(($urandom_range(3) == 0) ? SYNC_FIRST
						                                            : 8'($urandom_range(255)));
					end
				end
				foreach (frame_buf[i]) begin
					item = '{frame_buf[i], 1'b0, IDLE_RES};
					stream_q.push_back(item);
				end
				phase_bytes += frame_buf.size();
			end
		end

		// Drain: every byte offered and taken, every result seen, then a
		// short tail to catch any result the framer should not produce.
		while (stream_q.size() != 0 || rx_valid || status_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0) begin
			$display("binary_block_framer_crc16 test passed");
		end else begin
			$display("binary_block_framer_crc16 test failed");
		end
		$finish;
	end

endmodule

/* files.f */
hdl/bbfc16_pkg.sv
hdl/binary_block_framer_crc16.sv
tb/sv/tb_binary_block_framer_crc16.sv
